// ----- hw/rtl/cpt_pkg.sv -----
// Shared types, constants and codes for the pairwise tally block.
// No dependencies; used by cpt_ctrl, cpt_datapath and condorcet_pairwise_tally.
`default_nettype none

package cpt_pkg;

    localparam int MAX_CAND   = 16;
    localparam int SCORE_BITS = 16;
    localparam int CAND_W     = $clog2(MAX_CAND);
    localparam int NUM_W      = 5;
    localparam int ADDR_W     = 2 * CAND_W;
    localparam int DEPTH      = MAX_CAND * MAX_CAND;

    typedef logic [CAND_W-1:0]            t_cand;
    typedef logic [NUM_W-1:0]             t_num;
    typedef logic [MAX_CAND-1:0]          t_mask;
    typedef logic signed [SCORE_BITS-1:0] t_score;
    typedef logic [ADDR_W-1:0]            t_addr;
    typedef logic [1:0]                   t_func;

    localparam t_func FUNC_ADD   = 2'd0;
    localparam t_func FUNC_REM   = 2'd1;
    localparam t_func FUNC_CLEAR = 2'd2;
    localparam t_func FUNC_QUERY = 2'd3;

    localparam t_score SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
    localparam t_score SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

    localparam t_num NUM_RESET = t_num'(MAX_CAND);

    typedef struct packed {
        logic latch;
        logic clear_all;
        logic seen_clr;
        logic seen_mark;
        logic cnt_clr;
        logic cnt_inc;
        logic mem_rd;
        logic mem_wr;
        logic row_sel_cand;
        logic out_win;
        logic out_found;
        logic out_query;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  is_last;
        logic  elem_ok;
        logic  j_active;
        logic  cnt_last;
        logic  win_hit;
    } t_sts;

endpackage

`default_nettype wire

// ----- hw/rtl/condorcet_pairwise_tally.sv -----
// Top level of the pairwise preference tally with Condorcet winner search.
// Depends on cpt_pkg, cpt_ctrl and cpt_datapath.
//
// Usage:
//   Command channel: an item (i_func, i_candidate, i_last_rank) is taken at a
//   rising edge with start high and busy low. Ballots arrive one rank per item.
//   Config: i_cfg_we writes i_cfg_wdata (candidates in use) at once.
//   Results: o_valid marks one cycle carrying o_result_kind, o_winner_found,
//   o_winner and o_beaten_mask. The receiver cannot stall; results are not held.
// Sequencing (n = candidates in use, s = ballot candidates already seen):
//   Query: result registered from the dispatch state; busy only in that state.
//   Add/remove element: dispatch, then a column update that steps through the n
//   candidates in use, one pass over the score memory with one read and one
//   write slot for each of the s seen entries, then a done state.
//   Ballot end and clear: winner scan of up to n beats rows, one row per cycle,
//   then the report strobe. Items causing no result finish when busy drops.
// Reset: scores read as zero (per-entry valid bits), ballot set emptied,
//   candidates in use set to 16. No clearing pass is needed.
`default_nettype none

module condorcet_pairwise_tally (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_func,
    input  wire  [3:0]  i_candidate,
    input  wire         i_last_rank,
    input  wire         i_cfg_we,
    input  wire  [4:0]  i_cfg_wdata,
    output logic        o_valid,
    output logic        o_result_kind,
    output logic        o_winner_found,
    output logic [3:0]  o_winner,
    output logic [15:0] o_beaten_mask
);

    cpt_pkg::t_cmd cmd;
    cpt_pkg::t_sts sts;

    cpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cpt_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_func         (i_func),
        .i_candidate    (i_candidate),
        .i_last_rank    (i_last_rank),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_result_kind  (o_result_kind),
        .o_winner_found (o_winner_found),
        .o_winner       (o_winner),
        .o_beaten_mask  (o_beaten_mask)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/cpt_ctrl.sv -----
// Sequencer for the pairwise tally: dispatch, column update loop, winner scan.
// Depends on cpt_pkg; drives cpt_datapath through t_cmd, reads t_sts.
`default_nettype none

module cpt_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    output logic           busy,
    input  cpt_pkg::t_sts  i_sts,
    output cpt_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_URD   = 3'd2;
    localparam logic [2:0] S_UWR   = 3'd3;
    localparam logic [2:0] S_UDONE = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.func)
                    cpt_pkg::FUNC_QUERY: begin
                        o_cmd.row_sel_cand = 1'b1;
                        o_cmd.out_query    = 1'b1;
                        n_state            = S_IDLE;
                    end
                    cpt_pkg::FUNC_CLEAR: begin
                        o_cmd.clear_all = 1'b1;
                        o_cmd.seen_clr  = 1'b1;
                        o_cmd.cnt_clr   = 1'b1;
                        n_state         = S_SCAN;
                    end
                    default: begin
                        if (i_sts.elem_ok) begin
                            o_cmd.cnt_clr = 1'b1;
                            n_state       = S_URD;
                        end else if (i_sts.is_last) begin
                            o_cmd.seen_clr = 1'b1;
                            o_cmd.cnt_clr  = 1'b1;
                            n_state        = S_SCAN;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_URD: begin
                if (i_sts.j_active) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = S_UWR;
                end else if (i_sts.cnt_last) begin
                    n_state = S_UDONE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_UWR: begin
                o_cmd.mem_wr = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_UDONE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_URD;
                end
            end
            S_UDONE: begin
                if (i_sts.is_last) begin
                    o_cmd.seen_clr = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    n_state        = S_SCAN;
                end else begin
                    o_cmd.seen_mark = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_sts.win_hit) begin
                    o_cmd.out_win   = 1'b1;
                    o_cmd.out_found = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_sts.cnt_last) begin
                    o_cmd.out_win = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cpt_datapath.sv -----
// Datapath: score memory with valid bits, beats matrix, ballot set, counter, result regs.
// Depends on cpt_pkg; commanded by cpt_ctrl.
`default_nettype none

module cpt_datapath (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [4:0]            i_cfg_wdata,
    input  wire  [1:0]            i_func,
    input  wire  [3:0]            i_candidate,
    input  wire                   i_last_rank,
    input  cpt_pkg::t_cmd         i_cmd,
    output cpt_pkg::t_sts         o_sts,
    output logic                  o_valid,
    output logic                  o_result_kind,
    output logic                  o_winner_found,
    output logic [3:0]            o_winner,
    output logic [15:0]           o_beaten_mask
);

    cpt_pkg::t_num   r_cfg;
    cpt_pkg::t_num   eff_n;
    cpt_pkg::t_mask  use_mask;

    cpt_pkg::t_func  r_func;
    cpt_pkg::t_cand  r_cand;
    logic            r_last;

    cpt_pkg::t_cand  r_cnt;
    cpt_pkg::t_mask  r_seen;

    cpt_pkg::t_score mem [cpt_pkg::DEPTH];
    logic [cpt_pkg::DEPTH-1:0] r_valid;
    cpt_pkg::t_score r_rd_jc;
    cpt_pkg::t_score r_rd_cj;
    logic            r_v_jc;
    logic            r_v_cj;
    cpt_pkg::t_score cur_jc;
    cpt_pkg::t_score cur_cj;
    cpt_pkg::t_score new_jc;
    cpt_pkg::t_addr  a_jc;
    cpt_pkg::t_addr  a_cj;

    cpt_pkg::t_mask  r_beats [cpt_pkg::MAX_CAND];
    cpt_pkg::t_cand  row_addr;
    cpt_pkg::t_mask  row;
    cpt_pkg::t_mask  others;
    logic            cand_in_use;

    logic            r_out_valid;
    logic            r_kind;
    logic            r_found;
    cpt_pkg::t_cand  r_winner;
    cpt_pkg::t_mask  r_mask;

    // Register value 0 acts as 1, values above the maximum are clamped.
    always_comb begin
        if (r_cfg == '0) begin
            eff_n = cpt_pkg::t_num'(1);
        end else if (r_cfg > cpt_pkg::t_num'(cpt_pkg::MAX_CAND)) begin
            eff_n = cpt_pkg::t_num'(cpt_pkg::MAX_CAND);
        end else begin
            eff_n = r_cfg;
        end
        for (int k = 0; k < cpt_pkg::MAX_CAND; k++) begin
            use_mask[k] = (cpt_pkg::t_num'(k) < eff_n);
        end
    end

    assign a_jc = {r_cnt, r_cand};
    assign a_cj = {r_cand, r_cnt};

    assign cur_jc = r_v_jc ? r_rd_jc : '0;
    assign cur_cj = r_v_cj ? r_rd_cj : '0;

    always_comb begin
        if (r_func == cpt_pkg::FUNC_REM) begin
            new_jc = (cur_jc == cpt_pkg::SCORE_MIN) ? cur_jc : cur_jc - cpt_pkg::t_score'(1);
        end else begin
            new_jc = (cur_jc == cpt_pkg::SCORE_MAX) ? cur_jc : cur_jc + cpt_pkg::t_score'(1);
        end
    end

    assign row_addr    = i_cmd.row_sel_cand ? r_cand : r_cnt;
    assign row         = r_beats[row_addr];
    assign others      = use_mask & ~(cpt_pkg::t_mask'(1) << r_cnt);
    assign cand_in_use = ({1'b0, r_cand} < eff_n);

    assign o_sts.func     = r_func;
    assign o_sts.is_last  = r_last;
    assign o_sts.elem_ok  = cand_in_use && !r_seen[r_cand];
    assign o_sts.j_active = r_seen[r_cnt] && ({1'b0, r_cnt} < eff_n);
    assign o_sts.cnt_last = ({1'b0, r_cnt} == (eff_n - cpt_pkg::t_num'(1)));
    assign o_sts.win_hit  = ((row & others) == others);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= cpt_pkg::NUM_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func <= i_func;
            r_cand <= i_candidate;
            r_last <= i_last_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + cpt_pkg::t_cand'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.seen_clr) begin
            r_seen <= '0;
        end else if (i_cmd.seen_mark) begin
            r_seen[r_cand] <= 1'b1;
        end
    end

    // Score memory: one write, two reads, registered read data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[a_jc] <= new_jc;
        end
        if (i_cmd.mem_rd) begin
            r_rd_jc <= mem[a_jc];
            r_rd_cj <= mem[a_cj];
            r_v_jc  <= r_valid[a_jc];
            r_v_cj  <= r_valid[a_cj];
        end
    end

    // Entries not yet written since reset or clear read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            r_valid <= '0;
        end else if (i_cmd.mem_wr) begin
            r_valid[a_jc] <= 1'b1;
        end
    end

    // beats[i][j]: score[i][j] > score[j][i]
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            for (int k = 0; k < cpt_pkg::MAX_CAND; k++) begin
                r_beats[k] <= '0;
            end
        end else if (i_cmd.mem_wr) begin
            r_beats[r_cnt][r_cand] <= (new_jc > cur_cj);
            r_beats[r_cand][r_cnt] <= (cur_cj > new_jc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.out_win || i_cmd.out_query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_query) begin
            r_kind   <= 1'b1;
            r_found  <= 1'b0;
            r_winner <= '0;
            r_mask   <= cand_in_use ? (row & use_mask) : '0;
        end else if (i_cmd.out_win) begin
            r_kind   <= 1'b0;
            r_found  <= i_cmd.out_found;
            r_winner <= i_cmd.out_found ? r_cnt : '0;
            r_mask   <= '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_winner_found = r_found;
    assign o_winner       = r_winner;
    assign o_beaten_mask  = r_mask;

endmodule

`default_nettype wire

// ----- tb/tb_condorcet_pairwise_tally.sv -----
// Self-checking bench for condorcet_pairwise_tally: ballots, removals, clears and queries
// are predicted by a local copy of the score matrix and each result is checked field by field.
// Depends on cpt_pkg and the condorcet_pairwise_tally RTL.
`timescale 1ns / 1ps

module tb_condorcet_pairwise_tally;

    localparam int LATENCY       = 3 * cpt_pkg::MAX_CAND + 3;
    localparam int STALL_LIMIT   = 2000;
    localparam int FLOOR_BALLOTS = 40;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int PHASES        = 10;

    typedef struct {
        logic           kind;
        logic           found;
        cpt_pkg::t_cand win;
        cpt_pkg::t_mask mask;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_func;
    logic [3:0]  i_candidate;
    logic        i_last_rank;
    logic        i_cfg_we;
    logic [4:0]  i_cfg_wdata;
    logic        o_valid;
    logic        o_result_kind;
    logic        o_winner_found;
    logic [3:0]  o_winner;
    logic [15:0] o_beaten_mask;

    t_outcome       outcome_q[$];
    int             score [cpt_pkg::MAX_CAND][cpt_pkg::MAX_CAND];
    cpt_pkg::t_mask ballot_seen;
    cpt_pkg::t_num  cand_cfg;

    int items_sent;
    int results_checked;
    int cfg_writes;
    int mismatches;
    int stray_results;
    int idle_cycles;
    bit steady;

    condorcet_pairwise_tally u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_candidate    (i_candidate),
        .i_last_rank    (i_last_rank),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_result_kind  (o_result_kind),
        .o_winner_found (o_winner_found),
        .o_winner       (o_winner),
        .o_beaten_mask  (o_beaten_mask)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ---------------- tally predictor ----------------

    function automatic int active_n();
        if (cand_cfg == 0) return 1;
        if (cand_cfg > cpt_pkg::MAX_CAND) return cpt_pkg::MAX_CAND;
        return int'(cand_cfg);
    endfunction

    function automatic cpt_pkg::t_mask beats_of(int who);
        int             n;
        cpt_pkg::t_mask m;
        n = active_n();
        m = '0;
        if (who >= n) return '0;
        for (int j = 0; j < n; j++) begin
            if (j != who && score[who][j] > score[j][who]) m[j] = 1'b1;
        end
        return m;
    endfunction

    function automatic t_outcome winner_outcome();
        t_outcome r;
        int       n;
        n       = active_n();
        r.kind  = 1'b0;
        r.found = 1'b0;
        r.win   = '0;
        r.mask  = '0;
        for (int i = 0; i < n; i++) begin
            if ($countones(beats_of(i)) == n - 1) begin
                r.found = 1'b1;
                r.win   = cpt_pkg::t_cand'(i);
                return r;
            end
        end
        return r;
    endfunction

    function automatic void apply_rank(int c, bit removing);
        int n;
        n = active_n();
        if (c >= n || ballot_seen[c]) return;
        for (int j = 0; j < n; j++) begin
            if (ballot_seen[j]) begin
                if (removing) begin
                    if (score[j][c] > int'(cpt_pkg::SCORE_MIN)) score[j][c]--;
                end else begin
                    if (score[j][c] < int'(cpt_pkg::SCORE_MAX)) score[j][c]++;
                end
            end
        end
        ballot_seen[c] = 1'b1;
    endfunction

    function automatic void predict_outcome(cpt_pkg::t_func fn, cpt_pkg::t_cand cand,
                                            logic last);
        t_outcome r;
        case (fn)
            cpt_pkg::FUNC_ADD, cpt_pkg::FUNC_REM: begin
                apply_rank(int'(cand), fn == cpt_pkg::FUNC_REM);
                if (last) begin
                    ballot_seen = '0;
                    outcome_q.push_back(winner_outcome());
                end
            end
            cpt_pkg::FUNC_CLEAR: begin
                foreach (score[i, j]) score[i][j] = 0;
                ballot_seen = '0;
                outcome_q.push_back(winner_outcome());
            end
            default: begin
                r.kind  = 1'b1;
                r.found = 1'b0;
                r.win   = '0;
                r.mask  = beats_of(int'(cand));
                outcome_q.push_back(r);
            end
        endcase
    endfunction

    // ---------------- drivers ----------------

    task automatic send_item(input cpt_pkg::t_func fn, input cpt_pkg::t_cand cand,
                             input logic last);
        int gap;
        if (!steady && $urandom_range(99) < 35) begin
            gap = ($urandom_range(99) < 70) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            repeat (gap) begin
                @(negedge i_clk);
                start       <= 1'b0;
                i_func      <= cpt_pkg::t_func'($urandom);
                i_candidate <= cpt_pkg::t_cand'($urandom);
                i_last_rank <= 1'($urandom);
            end
        end
        @(negedge i_clk);
        start       <= 1'b1;
        i_func      <= fn;
        i_candidate <= cand;
        i_last_rank <= last;
        do @(posedge i_clk); while (busy);
        predict_outcome(fn, cand, last);
        items_sent++;
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        start <= 1'b0;
        while (outcome_q.size() != 0 || busy) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_cand_count(input cpt_pkg::t_num value);
        wait_quiet();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= cpt_pkg::t_num'($urandom);
        cand_cfg = value;
        cfg_writes++;
    endtask

    // Distinct in-use candidates in random order, optionally led by a favored one,
    // with occasional repeats, stray indices and queries mixed in.
    task automatic cast_ballot(input int favored);
        int             n, len, k, pick, tmp;
        int             slot [cpt_pkg::MAX_CAND];
        cpt_pkg::t_func fn;
        cpt_pkg::t_cand c;
        n = active_n();
        for (k = 0; k < n; k++) slot[k] = k;
        for (k = n - 1; k > 0; k--) begin
            pick       = $urandom_range(0, k);
            tmp        = slot[k];
            slot[k]    = slot[pick];
            slot[pick] = tmp;
        end
        if ($urandom_range(1) == 1) begin
            for (k = 0; k < n; k++) begin
                if (slot[k] == favored) begin
                    slot[k] = slot[0];
                    slot[0] = favored;
                end
            end
        end
        len = $urandom_range(1, n);
        fn  = ($urandom_range(99) < 80) ? cpt_pkg::FUNC_ADD : cpt_pkg::FUNC_REM;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(99) < 6)
                send_item(fn, cpt_pkg::t_cand'($urandom_range(0, cpt_pkg::MAX_CAND - 1)),
                          1'b0);
            if ($urandom_range(99) < 4)
                send_item(cpt_pkg::FUNC_QUERY,
                          cpt_pkg::t_cand'($urandom_range(0, cpt_pkg::MAX_CAND - 1)),
                          1'($urandom));
            c = cpt_pkg::t_cand'(slot[k]);
            if (k == len - 1 && $urandom_range(99) < 5)
                c = cpt_pkg::t_cand'($urandom_range(0, cpt_pkg::MAX_CAND - 1));
            send_item(fn, c, k == len - 1);
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_state();
        send_item(cpt_pkg::FUNC_QUERY, 4'd0, 1'b0);
        send_item(cpt_pkg::FUNC_QUERY, 4'd15, 1'b1);
        send_item(cpt_pkg::FUNC_CLEAR, 4'd0, 1'b0);
    endtask

    task automatic test_full_field_ballots();
        send_item(cpt_pkg::FUNC_ADD, 4'd3, 1'b0);
        send_item(cpt_pkg::FUNC_ADD, 4'd5, 1'b0);
        send_item(cpt_pkg::FUNC_ADD, 4'd15, 1'b1);
        send_item(cpt_pkg::FUNC_QUERY, 4'd3, 1'b0);
        // repeated rank inside one ballot
        send_item(cpt_pkg::FUNC_ADD, 4'd7, 1'b0);
        send_item(cpt_pkg::FUNC_ADD, 4'd7, 1'b0);
        send_item(cpt_pkg::FUNC_ADD, 4'd2, 1'b1);
        send_item(cpt_pkg::FUNC_QUERY, 4'd7, 1'b1);
    endtask

    task automatic test_two_candidates();
        write_cand_count(5'd2);
        send_item(cpt_pkg::FUNC_ADD, 4'd1, 1'b0);
        send_item(cpt_pkg::FUNC_ADD, 4'd0, 1'b1);
        send_item(cpt_pkg::FUNC_REM, 4'd1, 1'b0);
        send_item(cpt_pkg::FUNC_REM, 4'd0, 1'b1);
        // index outside the field still closes the ballot
        send_item(cpt_pkg::FUNC_ADD, 4'd9, 1'b1);
        send_item(cpt_pkg::FUNC_QUERY, 4'd9, 1'b0);
        send_item(cpt_pkg::FUNC_CLEAR, 4'd1, 1'b1);
    endtask

    task automatic test_config_extremes();
        write_cand_count(5'd0);
        send_item(cpt_pkg::FUNC_ADD, 4'd0, 1'b1);
        write_cand_count(5'd31);
        send_item(cpt_pkg::FUNC_QUERY, 4'd0, 1'b0);
        write_cand_count(5'd17);
        send_item(cpt_pkg::FUNC_ADD, 4'd4, 1'b0);
        // field shrinks while a ballot is open
        write_cand_count(5'd5);
        send_item(cpt_pkg::FUNC_ADD, 4'd2, 1'b1);
        send_item(cpt_pkg::FUNC_QUERY, 4'd4, 1'b0);
    endtask

    task automatic test_score_floor();
        write_cand_count(5'd2);
        send_item(cpt_pkg::FUNC_CLEAR, 4'd0, 1'b0);
        steady = 1'b1;
        repeat (FLOOR_BALLOTS) begin
            send_item(cpt_pkg::FUNC_REM, 4'd1, 1'b0);
            send_item(cpt_pkg::FUNC_REM, 4'd0, 1'b1);
        end
        send_item(cpt_pkg::FUNC_ADD, 4'd1, 1'b0);
        send_item(cpt_pkg::FUNC_ADD, 4'd0, 1'b1);
        send_item(cpt_pkg::FUNC_QUERY, 4'd0, 1'b0);
        send_item(cpt_pkg::FUNC_CLEAR, 4'd0, 1'b0);
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        cpt_pkg::t_num plan [PHASES];
        int            quota, favored, r;
        plan = '{5'd3, 5'd16, 5'd2, 5'd8, 5'd17, 5'd1, 5'd5, 5'd31, 5'd0, 5'd12};
        plan[PHASES-1] = cpt_pkg::t_num'($urandom_range(1, cpt_pkg::MAX_CAND));
        for (int p = 0; p < PHASES; p++) begin
            write_cand_count(plan[p]);
            steady  = (p == 2);
            favored = $urandom_range(0, active_n() - 1);
            quota   = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < quota) begin
                r = $urandom_range(99);
                if (r < 3)
                    send_item(cpt_pkg::FUNC_CLEAR, cpt_pkg::t_cand'($urandom), 1'($urandom));
                else if (r < 15)
                    send_item(cpt_pkg::FUNC_QUERY, cpt_pkg::t_cand'($urandom), 1'($urandom));
                else
                    cast_ballot(favored);
            end
        end
        steady = 1'b0;
    endtask

    // ---------------- result check ----------------

    always @(posedge i_clk) begin : check_results
        t_outcome want;
        t_outcome got;
        if (i_rst_n && o_valid) begin
            got.kind  = o_result_kind;
            got.found = o_winner_found;
            got.win   = o_winner;
            got.mask  = o_beaten_mask;
            if (outcome_q.size() == 0) begin
                stray_results++;
                if (mismatches + stray_results <= 10)
                    $display("tb: unexpected result kind=%0d found=%0d win=%0d mask=%h",
                             got.kind, got.found, got.win, got.mask);
            end else begin
                want = outcome_q.pop_front();
                results_checked++;
                if (got.kind !== want.kind || got.found !== want.found ||
                    got.win !== want.win || got.mask !== want.mask) begin
                    mismatches++;
                    if (mismatches + stray_results <= 10)
                        $display({"tb: mismatch exp kind=%0d found=%0d win=%0d mask=%h,",
                                  " got kind=%0d found=%0d win=%0d mask=%h"},
                                 want.kind, want.found, want.win, want.mask,
                                 got.kind, got.found, got.win, got.mask);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: no progress for %0d cycles, %0d results outstanding",
                         idle_cycles, outcome_q.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_func      = cpt_pkg::FUNC_ADD;
        i_candidate = '0;
        i_last_rank = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        steady      = 1'b0;
        cand_cfg    = cpt_pkg::NUM_RESET;
        ballot_seen = '0;
        foreach (score[i, j]) score[i][j] = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_full_field_ballots();
        test_two_candidates();
        test_config_extremes();
        test_score_floor();
        test_random_traffic();
        wait_quiet();

        $display("tb: %0d items sent, %0d results checked, %0d register writes",
                 items_sent, results_checked, cfg_writes);
        $display("tb: directed corners, repeated removals below zero and %0d random field sizes",
                 PHASES);
        if (mismatches == 0 && stray_results == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches, %0d unexpected results", mismatches, stray_results);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
